// File: sv/psrs_pkg.sv
package psrs_pkg;
	localparam int MAX_PAIRS = 64;
	localparam int IDX_W = $clog2(MAX_PAIRS);
	localparam int CNT_W = IDX_W + 1;
	localparam int POS_W = 12;
	localparam int SEG_W = 10;
	localparam int SCORE_W = 24;
	localparam int CFG_W = 12;
	localparam int IN_W = 2 * POS_W + 2 * SEG_W + SCORE_W;
	localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W = 6 + 2 * POS_W + SCORE_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
	localparam logic CFG_MIN_GAP = 1'b0;
	localparam logic CFG_FRAG = 1'b1;

	typedef struct packed {
		logic [POS_W-1:0] pos_first;
		logic [POS_W-1:0] pos_second;
		logic signed [SCORE_W-1:0] score;
		logic store;
		logic last;
	} req_t;

	typedef struct packed {
		logic [5:0] rank;
		logic [POS_W-1:0] pos_first;
		logic [POS_W-1:0] pos_second;
		logic signed [SCORE_W-1:0] score;
		logic none_kept;
		logic overflow;
		logic last;
	} res_t;

	function automatic logic [POS_W-1:0] absdiff(input logic [POS_W-1:0] a,
		input logic [POS_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction
endpackage

// File: sv/psrs_ram.sv
module psrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: sv/psrs_front.sv
module psrs_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [psrs_pkg::POS_W-1:0]  pos_first,
	input  logic [psrs_pkg::POS_W-1:0]  pos_second,
	input  logic [psrs_pkg::SEG_W-1:0]  seg_first,
	input  logic [psrs_pkg::SEG_W-1:0]  seg_second,
	input  logic [psrs_pkg::SCORE_W-1:0] score,
	input  logic                        last_pair,
	input  logic [psrs_pkg::CFG_W-1:0]  min_gap,
	output logic                        q_valid,
	input  logic                        q_ready,
	output psrs_pkg::req_t              q_req
);
	import psrs_pkg::*;
	// two-entry queue toward the back part
	req_t   buf_q [2];
	logic   wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;
	req_t r;

	always_comb begin
		r.pos_first = pos_first;
		r.pos_second = pos_second;
		r.score = score;
		r.last = last_pair;
		r.store = (seg_first != seg_second) && (absdiff(pos_first, pos_second) > min_gap);
	end
	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_req = buf_q[rp_q];

	always_ff @(posedge clk) if (push) buf_q[wp_q] <= r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// File: sv/psrs_back.sv
module psrs_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	output logic                       q_ready,
	input  psrs_pkg::req_t             q_req,
	input  logic [psrs_pkg::CFG_W-1:0] win_size,
	output logic                       res_valid,
	input  logic                       res_ready,
	output psrs_pkg::res_t             res
);
	import psrs_pkg::*;
	// Store is kept in rank order: a new pair walks down from the top,
	// moving each lower-scored entry up one slot, and lands behind all
	// pairs of equal or higher score.
	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001, S_INS_RD  = 9'b000000010, S_INS_CMP = 9'b000000100,
		S_SUP_RD  = 9'b000001000, S_SUP_LD  = 9'b000010000, S_SUP_CMP = 9'b000100000,
		S_EMIT_RD = 9'b001000000, S_EMIT_WR = 9'b010000000, S_EMPTY   = 9'b100000000
	} st_t;
	localparam int DW = SCORE_W + 2 * POS_W;

	st_t st_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic ovf_q;
	req_t cur_q;
	logic [MAX_PAIRS-1:0] kept_q;
	logic keep_q;
	logic [2*POS_W-1:0] a_q;
	logic [POS_W-1:0] half;

	logic we;
	logic [IDX_W-1:0] waddr, raddr;
	logic [DW-1:0] wdata, rdata;
	logic signed [SCORE_W-1:0] r_score;
	logic [POS_W-1:0] r_pf, r_ps, a_pf, a_ps;
	logic move_up, hit, i_end, is_last, emit_go;
	logic [MAX_PAIRS-1:0] above;

	psrs_ram #(.WIDTH(DW), .DEPTH(MAX_PAIRS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));

	assign {r_score, r_pf, r_ps} = rdata;
	assign {a_pf, a_ps} = a_q;
	assign half = {1'b0, win_size[CFG_W-1:1]};
	assign q_ready = (st_q == S_IDLE) && !res_valid;
	assign move_up = $signed(r_score) < $signed(cur_q.score);
	assign hit = kept_q[j_q] && (absdiff(a_pf, r_pf) < half) && (absdiff(a_ps, r_ps) < half);
	assign i_end = (CNT_W'(i_q) + CNT_W'(1)) == cnt_q;
	assign above = kept_q >> i_q;
	assign is_last = ~|above[MAX_PAIRS-1:1];
	assign emit_go = ((st_q == S_EMIT_WR) || (st_q == S_EMPTY)) && (!res_valid || res_ready);

	// insertion reads slot k-1 and writes slot k; the walk reads i, then j
	always_comb begin
		we = 1'b0;
		waddr = k_q;
		wdata = {cur_q.score, cur_q.pos_first, cur_q.pos_second};
		raddr = i_q;
		unique case (st_q)
			S_INS_RD: begin
				if (k_q == '0) we = 1'b1;
				else raddr = k_q - IDX_W'(1);
			end
			S_INS_CMP: begin
				we = 1'b1;
				if (move_up) begin
					wdata = rdata;
					raddr = k_q - IDX_W'(2);
				end
			end
			S_SUP_LD: raddr = j_q;
			S_SUP_CMP: raddr = j_q + IDX_W'(1);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			kept_q <= '0;
			keep_q <= 1'b0;
			res_valid <= 1'b0;
			res <= '0;
			cur_q <= '0;
			a_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			if (emit_go) res_valid <= 1'b1;
			else if (res_ready) res_valid <= 1'b0;
			unique case (st_q)
				S_IDLE: if (q_valid && q_ready) begin
					cur_q <= q_req;
					i_q <= '0;
					if (q_req.store && cnt_q != CNT_W'(MAX_PAIRS)) begin
						k_q <= cnt_q[IDX_W-1:0];
						st_q <= S_INS_RD;
					end else begin
						if (q_req.store) ovf_q <= 1'b1;
						st_q <= q_req.last ? ((cnt_q == '0) ? S_EMPTY : S_SUP_RD) : S_IDLE;
					end
				end
				// slot 0 reached: the new pair goes to the bottom
				S_INS_RD: begin
					if (k_q == '0) begin
						cnt_q <= cnt_q + CNT_W'(1);
						i_q <= '0;
						st_q <= cur_q.last ? S_SUP_RD : S_IDLE;
					end else begin
						st_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (move_up) begin
						k_q <= k_q - IDX_W'(1);
						if (k_q == IDX_W'(1)) st_q <= S_INS_RD;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
						i_q <= '0;
						st_q <= cur_q.last ? S_SUP_RD : S_IDLE;
					end
				end
				S_SUP_RD: begin
					j_q <= '0;
					st_q <= S_SUP_LD;
				end
				// hold pair i, then test it against every kept pair above it
				S_SUP_LD: begin
					a_q <= rdata[2*POS_W-1:0];
					keep_q <= 1'b1;
					if (i_q == '0) begin
						kept_q[0] <= 1'b1;
						if (i_end) begin
							i_q <= '0;
							st_q <= S_EMIT_RD;
						end else begin
							i_q <= i_q + IDX_W'(1);
							st_q <= S_SUP_RD;
						end
					end else begin
						st_q <= S_SUP_CMP;
					end
				end
				S_SUP_CMP: begin
					keep_q <= keep_q && !hit;
					if (j_q == i_q - IDX_W'(1)) begin
						kept_q[i_q] <= keep_q && !hit;
						if (i_end) begin
							i_q <= '0;
							st_q <= S_EMIT_RD;
						end else begin
							i_q <= i_q + IDX_W'(1);
							st_q <= S_SUP_RD;
						end
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				S_EMIT_RD: begin
					if (kept_q[i_q]) begin
						st_q <= S_EMIT_WR;
					end else if (i_end) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
						kept_q <= '0;
						i_q <= '0;
						st_q <= S_IDLE;
					end else begin
						i_q <= i_q + IDX_W'(1);
					end
				end
				S_EMIT_WR: if (emit_go) begin
					res <= '{rank: i_q, pos_first: r_pf, pos_second: r_ps, score: r_score,
						none_kept: 1'b0, overflow: ovf_q, last: is_last};
					if (i_end) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
						kept_q <= '0;
						i_q <= '0;
						st_q <= S_IDLE;
					end else begin
						i_q <= i_q + IDX_W'(1);
						st_q <= S_EMIT_RD;
					end
				end
				S_EMPTY: if (emit_go) begin
					res <= '{rank: '0, pos_first: '0, pos_second: '0, score: '0,
						none_kept: 1'b1, overflow: ovf_q, last: 1'b1};
					ovf_q <= 1'b0;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: sv/pair_score_rank_suppress.sv
// pair_score_rank_suppress: greedy suppression of scored residue pairs.
// Requests enter on s_axis (tvalid/tready/tdata, tlast = last pair) and
// results leave on m_axis (tlast = last result of a run, tuser = flags).
// Config writes (index 0 min_gap, 1 window size) use cfg_valid/cfg_ready;
// write them only between runs, with no request in flight.
// A front part filters requests into a two-entry queue; a back part keeps
// stored pairs in a score-ordered RAM by insertion, then walks it at the end.
// An accepted request is registered in the queue before the back part takes
// it. A stored request walks past each lower-scored pair in the RAM (at most
// the stored count); a dropped one does not touch the RAM.
// After the last request the back part tests each stored pair against the
// kept pairs ranked above it, then reads each pair and emits the kept ones
// in rank order. An empty run shows only its marker.
// The back part takes a new request only when idle with no result waiting;
// the queue then fills and the input stalls.
// Reset clears counts, marks and overflow; the store itself is not cleared.
// A stalled receiver holds the output register and stops the walk.
module pair_score_rank_suppress (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// pos_first[11:0], pos_second[23:12], seg_first[33:24], seg_second[43:34],
	// score[67:44], zero fill
	input  logic [psrs_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// rank[5:0], out_pos_first[17:6], out_pos_second[29:18], out_score[53:30]
	output logic [psrs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// none_kept[0], overflow[1]
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [psrs_pkg::CFG_W-1:0] cfg_data
);
	import psrs_pkg::*;
	logic [CFG_W-1:0] min_gap_q, frag_q;
	logic q_valid, q_ready;
	req_t q_req;
	res_t res;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q <= '0;
			frag_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_MIN_GAP) min_gap_q <= cfg_data;
			if (cfg_index == CFG_FRAG) frag_q <= cfg_data;
		end
	end

	psrs_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.pos_first(s_axis_tdata[11:0]), .pos_second(s_axis_tdata[23:12]),
		.seg_first(s_axis_tdata[33:24]), .seg_second(s_axis_tdata[43:34]),
		.score(s_axis_tdata[67:44]), .last_pair(s_axis_tlast), .min_gap(min_gap_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req));

	psrs_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.win_size(frag_q), .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
		.res(res));

	assign m_axis_tdata = {{(OUT_TDATA_W-OUT_W){1'b0}}, res.score, res.pos_second,
		res.pos_first, res.rank};
	assign m_axis_tuser = {res.overflow, res.none_kept};
	assign m_axis_tlast = res.last;

	// hold result stable while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
	// empty marker carries zero data
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == '0)
		else $error("empty marker malformed");
endmodule

// File: verif/pair_score_rank_suppress_tb.sv
module pair_score_rank_suppress_tb;
	import psrs_pkg::*;

	typedef struct {
		logic [POS_W-1:0] pf;
		logic [POS_W-1:0] ps;
		logic [SEG_W-1:0] sf;
		logic [SEG_W-1:0] ss;
		logic signed [SCORE_W-1:0] sc;
		logic last;
	} pair_req_t;

	typedef struct {
		logic [5:0] rank;
		logic [POS_W-1:0] pf;
		logic [POS_W-1:0] ps;
		logic signed [SCORE_W-1:0] sc;
		logic none_kept;
		logic ovf;
		logic last;
	} kept_pair_t;

	localparam int HOLD_LEN = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;

	pair_score_rank_suppress u_dut (.*);

	always #2 clk = ~clk;

	// Predictor state: the run's stored pairs and the live register copies.
	logic [POS_W-1:0] st_pf[MAX_PAIRS];
	logic [POS_W-1:0] st_ps[MAX_PAIRS];
	logic signed [SCORE_W-1:0] st_sc[MAX_PAIRS];
	int st_count;
	bit st_ovf;
	logic [CFG_W-1:0] min_gap_q, frag_q;

	pair_req_t pending_pairs[$];
	kept_pair_t kept_expected[$];

	int send_idle_pct, recv_stall_pct;
	bit recv_hold;        // long hold-off request from the stimulus
	int hold_cycles = 0;
	int mismatch_cnt;
	int sent_cnt, got_cnt, run_cnt;

	function automatic logic [POS_W-1:0] pos_dist(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// Fold one accepted request into the predictor; on the last pair rank,
	// suppress and queue the kept pairs.
	task automatic predict_pair(pair_req_t p);
		int order[MAX_PAIRS];
		bit kept[MAX_PAIRS];
		int r, a, b, half;
		bit keep;
		kept_pair_t k;
		if (p.sf != p.ss && pos_dist(p.pf, p.ps) > min_gap_q) begin
			if (st_count < MAX_PAIRS) begin
				st_pf[st_count] = p.pf;
				st_ps[st_count] = p.ps;
				st_sc[st_count] = p.sc;
				st_count++;
			end else begin
				st_ovf = 1'b1;
			end
		end
		if (!p.last) return;
		run_cnt++;
		if (st_count == 0) begin
			k = '{rank: '0, pf: '0, ps: '0, sc: '0, none_kept: 1'b1, ovf: st_ovf,
				last: 1'b1};
			kept_expected.push_back(k);
			st_ovf = 0;
			return;
		end
		for (int i = 0; i < st_count; i++) begin
			r = 0;
			for (int j = 0; j < st_count; j++)
				if (st_sc[j] > st_sc[i] || (st_sc[j] == st_sc[i] && j < i)) r++;
			order[r] = i;
		end
		half = frag_q / 2;
		for (int i = 0; i < st_count; i++) begin
			a = order[i];
			keep = 1;
			for (int j = 0; j < i; j++) begin
				b = order[j];
				if (kept[b] && pos_dist(st_pf[a], st_pf[b]) < half &&
						pos_dist(st_ps[a], st_ps[b]) < half) begin
					keep = 0;
					break;
				end
			end
			kept[a] = keep;
			if (keep) begin
				k = '{rank: 6'(i), pf: st_pf[a], ps: st_ps[a], sc: st_sc[a],
					none_kept: 1'b0, ovf: st_ovf, last: 1'b0};
				kept_expected.push_back(k);
			end
		end
		kept_expected[kept_expected.size()-1].last = 1;
		st_count = 0;
		st_ovf = 0;
	endtask

	// Driver: offer the head of the queue, advance on acceptance.
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			predict_pair(pending_pairs.pop_front());
			sent_cnt++;
		end
		if (s_axis_tvalid && !s_axis_tready) begin
			// hold the current request
		end else if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= {{(IN_TDATA_W-IN_W){1'b0}}, pending_pairs[0].sc,
				pending_pairs[0].ss, pending_pairs[0].sf, pending_pairs[0].ps,
				pending_pairs[0].pf};
			s_axis_tlast <= pending_pairs[0].last;
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// Long hold-off counter, kept in its own process.
	always @(posedge clk) begin
		if (!recv_hold) hold_cycles <= 0;
		else if (hold_cycles < HOLD_LEN) hold_cycles <= hold_cycles + 1;
	end

	// Monitor: compare every accepted result with the oldest expectation.
	always @(posedge clk) begin
		kept_pair_t e, g;
		if (m_axis_tvalid && m_axis_tready) begin
			got_cnt++;
			g.rank = m_axis_tdata[5:0];
			g.pf = m_axis_tdata[17:6];
			g.ps = m_axis_tdata[29:18];
			g.sc = m_axis_tdata[53:30];
			g.none_kept = m_axis_tuser[0];
			g.ovf = m_axis_tuser[1];
			g.last = m_axis_tlast;
			if (kept_expected.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected result rank=%0d pf=%0d ps=%0d", g.rank, g.pf, g.ps);
			end else begin
				e = kept_expected.pop_front();
				if (e.rank !== g.rank || e.pf !== g.pf || e.ps !== g.ps || e.sc !== g.sc ||
						e.none_kept !== g.none_kept || e.ovf !== g.ovf || e.last !== g.last) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("mismatch exp r=%0d %0d/%0d s=%0d n=%b o=%b l=%b got r=%0d %0d/%0d s=%0d n=%b o=%b l=%b",
							e.rank, e.pf, e.ps, e.sc, e.none_kept, e.ovf, e.last,
							g.rank, g.pf, g.ps, g.sc, g.none_kept, g.ovf, g.last);
				end
			end
		end
		m_axis_tready <= !(recv_hold && hold_cycles < HOLD_LEN) &&
			($urandom_range(99) >= recv_stall_pct);
	end

	task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_MIN_GAP) min_gap_q = val; else frag_q = val;
	endtask

	// Wait for the block to drain, then a pause for any in-flight work.
	task automatic drain();
		while (pending_pairs.size() > 0 || s_axis_tvalid || kept_expected.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic pair_req_t rand_pair(bit last, int span);
		pair_req_t p;
		p.pf = POS_W'($urandom_range(span));
		p.ps = POS_W'($urandom_range(span));
		p.sf = SEG_W'($urandom);
		p.ss = ($urandom_range(9) == 0) ? p.sf : SEG_W'($urandom);
		p.sc = ($urandom_range(3) == 0) ? SCORE_W'($urandom_range(3)) : SCORE_W'($urandom);
		p.last = last;
		return p;
	endfunction

	task automatic add_run(int n, int span);
		for (int i = 0; i < n; i++) pending_pairs.push_back(rand_pair(i == n - 1, span));
	endtask

	function automatic pair_req_t mk(int pf, int ps, int sf, int ss, int sc, bit last);
		pair_req_t p;
		p.pf = POS_W'(pf);
		p.ps = POS_W'(ps);
		p.sf = SEG_W'(sf);
		p.ss = SEG_W'(ss);
		p.sc = SCORE_W'(sc);
		p.last = last;
		return p;
	endfunction

	initial begin
		int left;
		st_count = 0; st_ovf = 0; min_gap_q = 0; frag_q = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		mismatch_cnt = 0; sent_cnt = 0; got_cnt = 0; run_cnt = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: empty run, equal segments, field extremes, ties, small window.
		pending_pairs.push_back(mk(5, 5, 1, 2, 100, 1));
		pending_pairs.push_back(mk(0, 4095, 7, 7, 5, 1));
		pending_pairs.push_back(mk(0, 4095, 0, 1023, 24'sh7fffff, 0));
		pending_pairs.push_back(mk(4095, 0, 1023, 0, -24'sd8388608, 0));
		pending_pairs.push_back(mk(10, 20, 3, 4, 50, 0));
		pending_pairs.push_back(mk(11, 21, 5, 6, 50, 0));
		pending_pairs.push_back(mk(12, 22, 8, 9, -1, 1));
		drain();
		write_reg(CFG_FRAG, 12'd1);
		write_reg(CFG_MIN_GAP, 12'd9);
		pending_pairs.push_back(mk(10, 19, 1, 2, 1, 0));
		pending_pairs.push_back(mk(10, 20, 1, 2, 1, 0));
		pending_pairs.push_back(mk(11, 21, 1, 2, 1, 1));
		drain();
		write_reg(CFG_FRAG, 12'd4095);
		write_reg(CFG_MIN_GAP, 12'd4095);
		pending_pairs.push_back(mk(0, 4095, 1, 2, 3, 1));
		drain();
		write_reg(CFG_MIN_GAP, 12'd0);
		write_reg(CFG_FRAG, 12'd20);
		pending_pairs.push_back(mk(100, 200, 1, 2, 9, 0));
		pending_pairs.push_back(mk(105, 205, 1, 2, 8, 0));
		pending_pairs.push_back(mk(110, 205, 1, 2, 7, 0));
		pending_pairs.push_back(mk(300, 400, 1, 2, 9, 1));
		drain();

		// Full store and overflow, with a long receiver hold-off on the output
		// while further runs pile up behind it and stall the input.
		add_run(90, 4095);
		add_run(5, 4095);
		add_run(5, 255);
		add_run(5, 4095);
		recv_hold = 1'b1;
		drain();
		recv_hold = 1'b0;

		// Random phases over several settings and idling mixes.
		left = 290;
		for (int ph = 0; left > 0; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			write_reg(CFG_MIN_GAP, (ph % 3 == 0) ? 12'd0 : 12'($urandom_range(40)));
			write_reg(CFG_FRAG, (ph % 5 == 0) ? 12'd4095 : 12'($urandom_range(200)));
			for (int r = 0; r < 4 && left > 0; r++) begin
				int n;
				n = $urandom_range(1, 12);
				add_run(n, ($urandom_range(1)) ? 255 : 4095);
				left -= n;
			end
			drain();
		end
		$display("runs checked: %0d, requests sent: %0d, results compared: %0d",
			run_cnt, sent_cnt, got_cnt);
		if (mismatch_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#4000000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
